### hw/rtl/pta_pkg.sv
`default_nettype none

package pta_pkg;

    // Field widths of the request and result items.
    localparam int unsigned OP_W    = 3;
    localparam int unsigned BASE_W  = 32;
    localparam int unsigned EXT_W   = 10;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned DIFF_LO_W = 12;

    // One base unit is this many extension ticks.
    localparam int unsigned TICKS_PER_BASE = 600;
    localparam int unsigned REM_W  = 10;
    // Widest dividend: a 10-bit extension plus a 32-bit tick count.
    localparam int unsigned DIV_W  = 33;

    // Packed stream widths, padded to whole bytes.
    localparam int unsigned IN_FIELDS_W  = OP_W + 2 * (BASE_W + EXT_W) + TICK_W;
    localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_FIELDS_W = BASE_W + EXT_W + TICK_W + 1;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Bit positions inside the result tdata.
    localparam int unsigned RES_EXT_LSB = BASE_W;
    localparam int unsigned TDIFF_LSB   = BASE_W + EXT_W;
    localparam int unsigned FLAG_BIT    = BASE_W + EXT_W + TICK_W;

    typedef enum logic [OP_W-1:0] {
        OP_DIFF        = 3'd0,
        OP_ADD_TICKS   = 3'd1,
        OP_ADD_TS      = 3'd2,
        OP_TICKS_TO_TS = 3'd3,
        OP_GT          = 3'd4,
        OP_GE          = 3'd5,
        OP_LE          = 3'd6
    } t_op;

    // Everything an item carries alongside the division.
    typedef struct packed {
        t_op                   op;
        logic [BASE_W-1:0]     base_add;
        logic [BASE_W-1:0]     diff_hi;
        logic [DIFF_LO_W-1:0]  diff_lo;
        logic                  flag;
    } t_side;

endpackage

`default_nettype wire

### hw/rtl/pta_front.sv
`default_nettype none

module pta_front import pta_pkg::*; #(
    parameter int unsigned NUM_W = 33
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [IN_TDATA_W-1:0] i_data,
    output logic                       o_valid,
    output logic [NUM_W-1:0]           o_num,
    output logic [REM_W-1:0]           o_rem,
    output t_side                      o_side
);

    logic [OP_W-1:0]   op_raw;
    logic [BASE_W-1:0] a_base;
    logic [EXT_W-1:0]  a_ext;
    logic [BASE_W-1:0] b_base;
    logic [EXT_W-1:0]  b_ext;
    logic [TICK_W-1:0] ticks;

    logic [DIV_W-1:0]  sum_ticks;
    logic [BASE_W-1:0] base_diff;
    logic              carry;
    logic              ext_gt;
    logic              ext_ge;
    logic              base_eq;
    logic              gt;

    logic              r_valid;
    logic [NUM_W-1:0]  r_num;
    t_side             r_side;
    logic [NUM_W-1:0]  n_num;
    t_side             n_side;

    assign op_raw = i_data[OP_W-1:0];
    assign a_base = i_data[OP_W +: BASE_W];
    assign a_ext  = i_data[OP_W + BASE_W +: EXT_W];
    assign b_base = i_data[OP_W + BASE_W + EXT_W +: BASE_W];
    assign b_ext  = i_data[OP_W + 2 * BASE_W + EXT_W +: EXT_W];
    assign ticks  = i_data[OP_W + 2 * (BASE_W + EXT_W) +: TICK_W];

    assign sum_ticks = {1'b0, ticks} + DIV_W'(a_ext);
    assign base_diff = a_base - b_base;
    assign carry     = (a_ext < b_ext);
    assign ext_gt    = (a_ext > b_ext);
    assign ext_ge    = (a_ext >= b_ext);
    assign base_eq   = (base_diff == '0);
    // Bases compare through their wrapped signed difference.
    assign gt        = base_eq ? ext_gt : ~base_diff[BASE_W-1];

    always_comb begin
        n_num           = '0;
        n_side.op       = t_op'(op_raw);
        n_side.base_add = '0;
        n_side.diff_hi  = base_diff - BASE_W'(carry);
        n_side.diff_lo  = DIFF_LO_W'(a_ext) - DIFF_LO_W'(b_ext)
                        + (carry ? DIFF_LO_W'(TICKS_PER_BASE) : '0);
        n_side.flag     = 1'b0;
        case (t_op'(op_raw))
            OP_ADD_TICKS: begin
                n_num           = NUM_W'(sum_ticks);
                n_side.base_add = a_base;
            end
            OP_ADD_TS: begin
                n_num           = NUM_W'(a_ext) + NUM_W'(b_ext);
                n_side.base_add = a_base + b_base;
            end
            OP_TICKS_TO_TS: begin
                n_num = NUM_W'(ticks);
            end
            OP_GT:   n_side.flag = gt;
            OP_GE:   n_side.flag = base_eq ? ext_ge : ~base_diff[BASE_W-1];
            OP_LE:   n_side.flag = ~gt;
            default: n_side.flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = '0;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### hw/rtl/pta_cell.sv
`default_nettype none

module pta_cell import pta_pkg::*; #(
    parameter int unsigned BITS  = 3,
    parameter int unsigned NUM_W = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire t_side            i_side,
    output logic                  o_valid,
    output logic [NUM_W-1:0]      o_num,
    output logic [REM_W-1:0]      o_rem,
    output t_side                 o_side
);

    logic             r_valid;
    logic [NUM_W-1:0] r_num;
    logic [REM_W-1:0] r_rem;
    t_side            r_side;
    logic [NUM_W-1:0] n_num;
    logic [REM_W-1:0] n_rem;

    // Restoring division steps: the dividend shifts out at the top of the
    // word while quotient bits shift in at the bottom.
    always_comb begin
        logic [REM_W:0] trial;
        n_num = i_num;
        n_rem = i_rem;
        for (int k = 0; k < BITS; k++) begin
            trial = {n_rem, n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (trial >= (REM_W + 1)'(TICKS_PER_BASE)) begin
                n_rem    = REM_W'(trial - (REM_W + 1)'(TICKS_PER_BASE));
                n_num[0] = 1'b1;
            end else begin
                n_rem = trial[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_side  = r_side;

endmodule

`default_nettype wire

### hw/rtl/pta_back.sv
`default_nettype none

module pta_back import pta_pkg::*; #(
    parameter int unsigned NUM_W = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [REM_W-1:0] i_rem,
    input  wire t_side            i_side,
    output logic                  o_valid,
    output logic [OUT_TDATA_W-1:0] o_data
);

    logic [BASE_W-1:0] res_base;
    logic [EXT_W-1:0]  res_ext;
    logic [TICK_W-1:0] tick_diff;
    logic              flag;
    logic [TICK_W-1:0] scaled_hi;

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic [OUT_TDATA_W-1:0] n_data;

    assign scaled_hi = i_side.diff_hi * TICK_W'(TICKS_PER_BASE);

    always_comb begin
        res_base  = '0;
        res_ext   = '0;
        tick_diff = '0;
        flag      = 1'b0;
        case (i_side.op)
            OP_DIFF: begin
                tick_diff = scaled_hi
                          + {{(TICK_W - DIFF_LO_W){i_side.diff_lo[DIFF_LO_W-1]}},
                             i_side.diff_lo};
            end
            OP_ADD_TICKS, OP_ADD_TS, OP_TICKS_TO_TS: begin
                res_base = i_side.base_add + i_num[BASE_W-1:0];
                res_ext  = i_rem;
            end
            OP_GT, OP_GE, OP_LE: begin
                flag = i_side.flag;
            end
            default: begin
                flag = 1'b0;
            end
        endcase
        n_data = OUT_TDATA_W'({flag, tick_diff, res_ext, res_base});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### hw/rtl/pcr_timestamp_alu_top.sv
// Channel    Direction  Ports                      Contents of tdata (lowest bit first)
// s_axis     in         tvalid, tready, tdata      opcode, a_base, a_ext, b_base, b_ext, ticks
// m_axis     out        tvalid, tready, tdata      res_base, res_ext, tick_diff, compare_flag
//
// One request enters per cycle while the row is not frozen; each result passes
// through the front stage, the row of division cells and the back stage.
// The length of the row follows from BITS_PER_CELL: each division cell retires BITS_PER_CELL
// quotient bits of the divide by 600.
// Reset clears the valid bits of every stage; data registers are not reset.
// A result that is not taken freezes the whole row and drops s_axis_tready in
// the same cycle; the row moves again as soon as the result is taken.
`default_nettype none

module pcr_timestamp_alu_top import pta_pkg::*; #(
    parameter int unsigned BITS_PER_CELL = 3
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // opcode[2:0], a_base[34:3], a_ext[44:35], b_base[76:45], b_ext[86:77],
    // ticks[118:87], zero pad above.
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // res_base[31:0], res_ext[41:32], tick_diff[73:42], compare_flag[74],
    // zero pad above.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    // Number of cells needed to retire every bit of the widest dividend.
    localparam int unsigned N_CELLS = (DIV_W + BITS_PER_CELL - 1) / BITS_PER_CELL;
    localparam int unsigned NUM_W   = N_CELLS * BITS_PER_CELL;

    // The whole row advances together whenever the output register is free
    // or its result is being taken.
    logic advance;

    logic             st_valid [N_CELLS+1];
    logic [NUM_W-1:0] st_num   [N_CELLS+1];
    logic [REM_W-1:0] st_rem   [N_CELLS+1];
    t_side            st_side  [N_CELLS+1];

    assign advance       = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = advance;

    // The front stage decodes the request, unpacks the dividend for the
    // divide by 600, prepares the difference and settles the compare operations.
    pta_front #(
        .NUM_W (NUM_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_valid (st_valid[0]),
        .o_num   (st_num[0]),
        .o_rem   (st_rem[0]),
        .o_side  (st_side[0])
    );

    // Each cell holds one request in flight and hands its partial quotient
    // and remainder to the next cell every cycle that the row advances.
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        pta_cell #(
            .BITS  (BITS_PER_CELL),
            .NUM_W (NUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (st_valid[g]),
            .i_num   (st_num[g]),
            .i_rem   (st_rem[g]),
            .i_side  (st_side[g]),
            .o_valid (st_valid[g+1]),
            .o_num   (st_num[g+1]),
            .o_rem   (st_rem[g+1]),
            .o_side  (st_side[g+1])
        );
    end

    // The back stage adds the quotient into the base, scales the base
    // difference to ticks and holds the finished result for the consumer.
    pta_back #(
        .NUM_W (NUM_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (st_valid[N_CELLS]),
        .i_num   (st_num[N_CELLS]),
        .i_rem   (st_rem[N_CELLS]),
        .i_side  (st_side[N_CELLS]),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### hw/rtl/pta_checker.sv
`default_nettype none

module pta_checker import pta_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [BASE_W-1:0] res_base;
    logic [EXT_W-1:0]  res_ext;
    logic [TICK_W-1:0] tick_diff;
    logic              flag;

    assign res_base  = m_axis_tdata[BASE_W-1:0];
    assign res_ext   = m_axis_tdata[RES_EXT_LSB +: EXT_W];
    assign tick_diff = m_axis_tdata[TDIFF_LSB +: TICK_W];
    assign flag      = m_axis_tdata[FLAG_BIT];

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    a_ext_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res_ext < EXT_W'(TICKS_PER_BASE))
        else $error("result extension not reduced below one base unit");

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (flag || tick_diff != '0) |-> res_base == '0 && res_ext == '0)
        else $error("timestamp result mixed with difference or compare result");

endmodule

bind pcr_timestamp_alu_top pta_checker u_pta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
